// ===== design/msw_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI switch package
// Shared sizes, request codes, result codes and the scan unit command type.
// ----------------------------------------------------------------------------
package msw_pkg;

  // Default map size: channels by notes
  localparam int MSW_CHANNELS = 16;
  localparam int MSW_NOTES    = 128;

  // Request modes
  localparam logic [1:0] MODE_EVENT  = 2'd0;
  localparam logic [1:0] MODE_TARGET = 2'd1;
  localparam logic [1:0] MODE_DRAIN  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_FWD      = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_ACK      = 2'd2;
  localparam logic [1:0] KIND_BUSY     = 2'd3;

  // MIDI message types (status high nibble)
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

  // Command to the note scan unit
  typedef struct packed {
    logic load;
    logic advance;
  } scan_cmd_t;

endpackage

// ===== design/midi_switch_with_note_flush.sv =====
// Results: a result strobes in the cycle after its request is accepted, except
// a drain tick on a pending flush, whose note-off follows the row load and scan.
// Throughput: note-on/off events hold busy for the map row update (ST_EV_WR);
// a drain tick on a pending flush holds busy until its note is found by the
// one-note-per-cycle row scan. All other requests can be issued every cycle.
// Reset: map rows read as empty via per-row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// MIDI switch with held-note flush
// Routes events to one of two outputs, tracks held notes in a channel by note
// bitmap and, after a target change, drains note-offs to the old output.
// ----------------------------------------------------------------------------
module midi_switch_with_note_flush
  import msw_pkg::*;
#(
  parameter int CHANNELS = MSW_CHANNELS,
  parameter int NOTES    = MSW_NOTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic       in_new_target,
  input  logic       in_is_midi,
  input  logic [7:0] in_status_byte,
  input  logic [6:0] in_data_one,
  input  logic [6:0] in_data_two,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic       out_port,
  output logic       out_is_midi,
  output logic [7:0] out_status,
  output logic [6:0] out_data_one,
  output logic [6:0] out_data_two,
  output logic       out_flush_active
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NT_W = (NOTES > 1) ? $clog2(NOTES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EV_WR,
    ST_DR_LOAD,
    ST_DR_SCAN
  } state_t;

  state_t state_r, state_nxt;

  logic                sel_r, sel_nxt;
  logic                flush_out_r, flush_out_nxt;
  logic                pending_r, pending_nxt;
  logic [CHANNELS-1:0] row_valid_r, row_valid_nxt;
  logic [CHANNELS-1:0] row_nz_r, row_nz_nxt;
  logic [CH_W-1:0]     ev_row_r, ev_row_nxt;
  logic [NT_W-1:0]     ev_note_r, ev_note_nxt;
  logic                ev_set_r, ev_set_nxt;
  logic [CH_W-1:0]     drain_row_r, drain_row_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic       out_port_r, out_port_nxt;
  logic       out_is_midi_r, out_is_midi_nxt;
  logic [7:0] out_status_r, out_status_nxt;
  logic [6:0] out_data_one_r, out_data_one_nxt;
  logic [6:0] out_data_two_r, out_data_two_nxt;
  logic       out_fa_r, out_fa_nxt;

  // RAM and scan unit signals
  logic             ram_we;
  logic [CH_W-1:0]  ram_raddr;
  logic [NOTES-1:0] ram_rdata;
  scan_cmd_t        scan_cmd;
  logic [NOTES-1:0] scan_load;
  logic [NOTES-1:0] scan_word;
  logic [NT_W-1:0]  scan_pos;
  logic             scan_hit;

  // Shared row modify path
  logic [CH_W-1:0]     wr_row;
  logic [NT_W-1:0]     wr_note;
  logic                wr_set;
  logic [NOTES-1:0]    wr_base;
  logic [NOTES-1:0]    wr_mask;
  logic [NOTES-1:0]    wr_word;
  logic                wr_nz;

  logic [CH_W-1:0]     in_row;
  logic                in_range;
  logic                in_note_msg;
  logic [CH_W-1:0]     top_row;
  logic [CHANNELS-1:0] other_nz;
  logic                any_left;

  // Decode the incoming event
  assign in_row      = CH_W'(in_status_byte[3:0]);
  assign in_range    = ({1'b0, in_status_byte[3:0]} < 5'(CHANNELS)) &&
                       ({1'b0, in_data_one} < 8'(NOTES));
  assign in_note_msg = (in_status_byte[7:4] == MIDI_NOTE_ON) ||
                       (in_status_byte[7:4] == MIDI_NOTE_OFF);

  // Pick the highest channel row that holds notes
  always_comb begin
    top_row = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (row_nz_r[i]) begin
        top_row = CH_W'(i);
      end
    end
  end

  // Set or clear one note in a row
  assign wr_mask = NOTES'(1) << wr_note;
  assign wr_word = wr_set ? (wr_base | wr_mask) : (wr_base & ~wr_mask);
  assign wr_nz   = |wr_word;

  // Notes left in other rows after the drained row is written back
  always_comb begin
    other_nz              = row_nz_r;
    other_nz[drain_row_r] = 1'b0;
  end
  assign any_left  = (other_nz != '0) || wr_nz;

  assign ram_raddr = (in_mode == MODE_DRAIN) ? top_row : in_row;
  assign scan_load = row_valid_r[drain_row_r] ? ram_rdata : '0;

  // Sequencer: next state, map bookkeeping and result
  always_comb begin
    state_nxt        = state_r;
    sel_nxt          = sel_r;
    flush_out_nxt    = flush_out_r;
    pending_nxt      = pending_r;
    row_valid_nxt    = row_valid_r;
    row_nz_nxt       = row_nz_r;
    ev_row_nxt       = ev_row_r;
    ev_note_nxt      = ev_note_r;
    ev_set_nxt       = ev_set_r;
    drain_row_nxt    = drain_row_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_port_nxt     = out_port_r;
    out_is_midi_nxt  = out_is_midi_r;
    out_status_nxt   = out_status_r;
    out_data_one_nxt = out_data_one_r;
    out_data_two_nxt = out_data_two_r;
    out_fa_nxt       = out_fa_r;
    scan_cmd         = '0;
    ram_we           = 1'b0;
    wr_row           = ev_row_r;
    wr_note          = ev_note_r;
    wr_set           = ev_set_r;
    wr_base          = row_valid_r[ev_row_r] ? ram_rdata : '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_ACK;
          out_port_nxt     = 1'b0;
          out_is_midi_nxt  = 1'b0;
          out_status_nxt   = '0;
          out_data_one_nxt = '0;
          out_data_two_nxt = '0;
          out_fa_nxt       = pending_r;
          unique case (in_mode)
            MODE_EVENT: begin
              if (pending_r) begin
                out_kind_nxt = KIND_BUSY;
              end else begin
                out_kind_nxt = KIND_FWD;
                out_port_nxt = sel_r;
                if (in_is_midi) begin
                  out_is_midi_nxt  = 1'b1;
                  out_status_nxt   = in_status_byte;
                  out_data_one_nxt = in_data_one;
                  out_data_two_nxt = in_data_two;
                  // Note on/off in the map: update the row next cycle
                  if (in_range && in_note_msg) begin
                    ev_row_nxt  = in_row;
                    ev_note_nxt = NT_W'(in_data_one);
                    ev_set_nxt  = (in_status_byte[7:4] == MIDI_NOTE_ON);
                    state_nxt   = ST_EV_WR;
                  end
                end
              end
            end
            MODE_TARGET: begin
              if (pending_r) begin
                out_kind_nxt = KIND_BUSY;
              end else if (in_new_target != sel_r) begin
                flush_out_nxt = sel_r;
                sel_nxt       = in_new_target;
                pending_nxt   = (row_nz_r != '0);
                out_fa_nxt    = (row_nz_r != '0);
              end
            end
            MODE_DRAIN: begin
              // Read the top held row, result comes after the scan
              if (pending_r) begin
                out_valid_nxt = 1'b0;
                drain_row_nxt = top_row;
                state_nxt     = ST_DR_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EV_WR: begin
        ram_we                = 1'b1;
        row_valid_nxt[wr_row] = 1'b1;
        row_nz_nxt[wr_row]    = wr_nz;
        state_nxt             = ST_IDLE;
      end
      ST_DR_LOAD: begin
        scan_cmd.load = 1'b1;
        state_nxt     = ST_DR_SCAN;
      end
      ST_DR_SCAN: begin
        wr_row  = drain_row_r;
        wr_note = scan_pos;
        wr_set  = 1'b0;
        wr_base = scan_word;
        if (scan_hit) begin
          // Clear the found note and emit its note-off
          ram_we                = 1'b1;
          row_valid_nxt[wr_row] = 1'b1;
          row_nz_nxt[wr_row]    = wr_nz;
          pending_nxt           = any_left;
          out_valid_nxt         = 1'b1;
          out_kind_nxt          = KIND_NOTE_OFF;
          out_port_nxt          = flush_out_r;
          out_is_midi_nxt       = 1'b1;
          out_status_nxt        = {MIDI_NOTE_OFF, 4'(drain_row_r)};
          out_data_one_nxt      = 7'(scan_pos);
          out_data_two_nxt      = '0;
          out_fa_nxt            = any_left;
          state_nxt             = ST_IDLE;
        end else begin
          scan_cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      flush_out_r <= 1'b0;
      pending_r   <= 1'b0;
      row_valid_r <= '0;
      row_nz_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      flush_out_r <= flush_out_nxt;
      pending_r   <= pending_nxt;
      row_valid_r <= row_valid_nxt;
      row_nz_r    <= row_nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ev_row_r       <= ev_row_nxt;
    ev_note_r      <= ev_note_nxt;
    ev_set_r       <= ev_set_nxt;
    drain_row_r    <= drain_row_nxt;
    out_kind_r     <= out_kind_nxt;
    out_port_r     <= out_port_nxt;
    out_is_midi_r  <= out_is_midi_nxt;
    out_status_r   <= out_status_nxt;
    out_data_one_r <= out_data_one_nxt;
    out_data_two_r <= out_data_two_nxt;
    out_fa_r       <= out_fa_nxt;
  end

  // Held-note map: one row of notes per channel
  msw_ram #(
    .WIDTH (NOTES),
    .DEPTH (CHANNELS),
    .AW    (CH_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_row),
    .wdata (wr_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Highest-note search over one row
  msw_scan #(
    .NOTES (NOTES),
    .NT_W  (NT_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (scan_cmd),
    .load_word (scan_load),
    .word      (scan_word),
    .pos       (scan_pos),
    .hit       (scan_hit)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_port         = out_port_r;
  assign out_is_midi      = out_is_midi_r;
  assign out_status       = out_status_r;
  assign out_data_one     = out_data_one_r;
  assign out_data_two     = out_data_two_r;
  assign out_flush_active = out_fa_r;

  // A pending flush always has notes left to drain
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (row_nz_r != '0))
    else $error("flush pending with empty map");

  // The row under scan holds at least one note
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DR_SCAN) |-> row_nz_r[drain_row_r])
    else $error("scanning an empty row");

  // A row marked as holding notes has been written since reset
  assert property (@(posedge clk) disable iff (!rst_n)
    (row_nz_r & ~row_valid_r) == '0)
    else $error("non-empty flag on unwritten row");

  // Generated note-offs come only from a finished scan
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_NOTE_OFF)) |-> ($past(state_r) == ST_DR_SCAN))
    else $error("note-off without scan");

  // Row load is always followed by the scan
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DR_LOAD) |=> (state_r == ST_DR_SCAN))
    else $error("row load not followed by scan");

endmodule

// ===== design/msw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/msw_scan.sv =====
// ----------------------------------------------------------------------------
// Note scan unit
// Holds one row of the held-note map and, while commanded to advance, tests one
// note per cycle, from the top note down, to find the highest held note.
// ----------------------------------------------------------------------------
module msw_scan
  import msw_pkg::*;
#(
  parameter int NOTES = MSW_NOTES,
  parameter int NT_W  = (NOTES > 1) ? $clog2(NOTES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_cmd_t        cmd,
  input  logic [NOTES-1:0] load_word,
  output logic [NOTES-1:0] word,
  output logic [NT_W-1:0]  pos,
  output logic             hit
);

  logic [NOTES-1:0] word_r;
  logic [NT_W-1:0]  pos_r;

  // Load a row and start at the top note, or step one note down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= NT_W'(NOTES - 1);
    end else if (cmd.load) begin
      word_r <= load_word;
      pos_r  <= NT_W'(NOTES - 1);
    end else if (cmd.advance) begin
      pos_r <= pos_r - 1'b1;
    end
  end

  // Test the current note
  assign hit  = word_r[pos_r];
  assign word = word_r;
  assign pos  = pos_r;

endmodule
